[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/prt_pkg.sv]
// ----------------------------------------------------------------------------
// prt_pkg
// Types and constants of the ping round-trip tracker.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int TIME_W            = 48;
    localparam int TAG_W             = 16;
    localparam int CMD_W             = 2;
    localparam int DEF_ENTRY_COUNT   = 10;

    // Command codes; code 3 is unused and yields an all-zero result
    typedef enum logic [CMD_W-1:0] {
        CMD_SEND  = 2'd0,
        CMD_REPLY = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    // One table entry as stored in the entry memory
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] sent;
        logic [TIME_W-1:0] recv;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FILL,
        ST_DIV,
        ST_WAIT
    } state_t;

endpackage

[design/prt_ram.sv]
// ----------------------------------------------------------------------------
// prt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/prt_div.sv]
// ----------------------------------------------------------------------------
// prt_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module prt_div #(
    parameter int DVD_W = 53,
    parameter int DVS_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEPS = (DVD_W + 1) / 2;
    localparam int PAD_W = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0] q_reg;
    logic [PAD_W-1:0] q_next;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;

    // Two restoring steps on the narrow remainder
    always_comb
    begin
        q_next   = q_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < 2; i++)
        begin
            trial  = {rem_next, q_next[PAD_W-1]};
            q_next = {q_next[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial     = trial - {1'b0, dvs_reg};
                q_next[0] = 1'b1;
            end
            rem_next = trial[DVS_W-1:0];
        end
    end

    // Step counter and completion strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg <= CNT_W'(STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= PAD_W'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg[DVD_W-1:0];

endmodule

[design/ping_round_trip_tracker.sv]
// ----------------------------------------------------------------------------
// ping_round_trip_tracker
// Ping table with send, reply and average-query commands.
// ----------------------------------------------------------------------------
// One item is taken at a time: an item is accepted on a clock edge with start
// high and busy low, and its single result appears on issued_tag, average_ms
// and tag_matched for exactly one cycle with done high; the receiver cannot
// stall it, and a new item may be started in that same cycle. The table sits
// in one memory that is walked one entry per cycle through its single read
// port, so latency depends on the command and the table contents: a send
// scans to the first free entry and writes it there, a send into a full
// table moves every entry down one place and writes the last one, a reply
// scans until its tag matches or the table ends, and a query scans the whole
// table and then, when something is measured and the sum is positive, runs
// the divider at two quotient bits a cycle. Entries reset to zero through
// per-entry valid flags, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module ping_round_trip_tracker
    import prt_pkg::*;
#(
    parameter int ENTRY_COUNT = DEF_ENTRY_COUNT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CMD_W-1:0]  command,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [TAG_W-1:0]  reply_tag,
    output logic              busy,
    output logic              done,
    output logic [TAG_W-1:0]  issued_tag,
    output logic [TIME_W-1:0] average_ms,
    output logic              tag_matched
);

    localparam int IDX_W = $clog2(ENTRY_COUNT);
    localparam int CNT_W = $clog2(ENTRY_COUNT + 1);
    localparam int SUM_W = TIME_W + 1 + $clog2(ENTRY_COUNT);
    localparam int DVD_W = SUM_W - 1;
    localparam int DVS_W = CNT_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);
    localparam logic [IDX_W-1:0] PREV_IDX = IDX_W'(ENTRY_COUNT - 2);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    cmd_t               cmd_reg, cmd_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [TAG_W-1:0]   rtag_reg, rtag_next;
    logic [TAG_W-1:0]   prev_tag_reg, prev_tag_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ENTRY_COUNT-1:0] valid_reg;
    logic               rd_valid_reg;
    logic               done_reg, done_next;
    logic [TAG_W-1:0]   issued_reg, issued_next;
    logic [TIME_W-1:0]  average_reg, average_next;
    logic               matched_reg, matched_next;

    logic               ram_rd_en;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    entry_t             ram_wr_data;
    entry_t             cur;
    logic [TAG_W-1:0]   new_tag;
    logic [TIME_W:0]    diff;
    logic               div_start;
    logic               div_done;
    logic [DVD_W-1:0]   div_quot;

    // Entry memory
    prt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRY_COUNT)
    ) u_prt_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Divider for the mean: sum / (2 * count)
    prt_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_prt_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg[DVD_W-1:0]),
        .divisor  ({count_reg, 1'b0}),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Never-written entries read as zero
    assign cur     = rd_valid_reg ? entry_t'(ram_rd_data) : '0;
    assign new_tag = prev_tag_reg + TAG_W'(1);
    assign diff    = {1'b0, cur.recv} - {1'b0, cur.sent};

    // Sequencer: next state, memory access, results
    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        cmd_next      = cmd_reg;
        now_next      = now_reg;
        rtag_next     = rtag_reg;
        prev_tag_next = prev_tag_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        issued_next   = issued_reg;
        average_next  = average_reg;
        matched_next  = matched_reg;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = ptr_reg + IDX_W'(1);
        ram_wr_en     = 1'b0;
        ram_wr_addr   = ptr_reg;
        ram_wr_data   = cur;
        div_start     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = cmd_t'(command);
                    now_next      = now_ms;
                    rtag_next     = reply_tag;
                    prev_tag_next = '0;
                    sum_next      = '0;
                    count_next    = '0;
                    ptr_next      = '0;
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = '0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                case (cmd_reg)
                    CMD_SEND:
                    begin
                        if (cur.sent == '0)
                        begin
                            ram_wr_en    = 1'b1;
                            ram_wr_data  = '{tag: new_tag, sent: now_reg, recv: '0};
                            done_next    = 1'b1;
                            issued_next  = new_tag;
                            average_next = '0;
                            matched_next = 1'b0;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            prev_tag_next = cur.tag;
                            ram_rd_en     = 1'b1;
                            if (ptr_reg == LAST_IDX)
                            begin
                                // Table full: move entries down by one
                                ram_rd_addr = IDX_W'(1);
                                ptr_next    = '0;
                                state_next  = ST_SHIFT;
                            end
                            else
                            begin
                                ptr_next = ptr_reg + IDX_W'(1);
                            end
                        end
                    end

                    CMD_REPLY:
                    begin
                        if (cur.tag == rtag_reg)
                        begin
                            ram_wr_en    = 1'b1;
                            ram_wr_data  = '{tag: cur.tag, sent: cur.sent, recv: now_reg};
                            done_next    = 1'b1;
                            issued_next  = '0;
                            average_next = '0;
                            matched_next = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        else if (ptr_reg == LAST_IDX)
                        begin
                            done_next    = 1'b1;
                            issued_next  = '0;
                            average_next = '0;
                            matched_next = 1'b0;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            ram_rd_en = 1'b1;
                            ptr_next  = ptr_reg + IDX_W'(1);
                        end
                    end

                    CMD_QUERY:
                    begin
                        // Accumulate signed round trips of measured entries
                        if (cur.sent != '0 && cur.recv != '0)
                        begin
                            sum_next   = sum_reg + {{(SUM_W-TIME_W-1){diff[TIME_W]}}, diff};
                            count_next = count_reg + CNT_W'(1);
                        end
                        if (ptr_reg == LAST_IDX)
                        begin
                            state_next = ST_DIV;
                        end
                        else
                        begin
                            ram_rd_en = 1'b1;
                            ptr_next  = ptr_reg + IDX_W'(1);
                        end
                    end

                    default:
                    begin
                        done_next    = 1'b1;
                        issued_next  = '0;
                        average_next = '0;
                        matched_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                endcase
            end

            ST_SHIFT:
            begin
                // cur holds entry ptr+1, written one place down
                ram_wr_en = 1'b1;
                if (ptr_reg == PREV_IDX)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_reg + IDX_W'(2);
                    ptr_next    = ptr_reg + IDX_W'(1);
                end
            end

            ST_FILL:
            begin
                // prev_tag_reg still holds the old tag of the last entry
                ram_wr_en    = 1'b1;
                ram_wr_addr  = LAST_IDX;
                ram_wr_data  = '{tag: new_tag, sent: now_reg, recv: '0};
                done_next    = 1'b1;
                issued_next  = new_tag;
                average_next = '0;
                matched_next = 1'b0;
                state_next   = ST_IDLE;
            end

            ST_DIV:
            begin
                // Zero or negative mean, or nothing measured, gives 0
                if (!sum_reg[SUM_W-1] && sum_reg != '0 && count_reg != '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT;
                end
                else
                begin
                    done_next    = 1'b1;
                    issued_next  = '0;
                    average_next = '0;
                    matched_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            ST_WAIT:
            begin
                if (div_done)
                begin
                    done_next    = 1'b1;
                    issued_next  = '0;
                    average_next = div_quot[TIME_W-1:0];
                    matched_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            done_reg     <= 1'b0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (ram_wr_en)
            begin
                valid_reg[ram_wr_addr] <= 1'b1;
            end
            if (ram_rd_en)
            begin
                rd_valid_reg <= valid_reg[ram_rd_addr];
            end
        end
    end

    // Item and result registers
    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        cmd_reg      <= cmd_next;
        now_reg      <= now_next;
        rtag_reg     <= rtag_next;
        prev_tag_reg <= prev_tag_next;
        sum_reg      <= sum_next;
        count_reg    <= count_next;
        issued_reg   <= issued_next;
        average_reg  <= average_next;
        matched_reg  <= matched_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign issued_tag  = issued_reg;
    assign average_ms  = average_reg;
    assign tag_matched = matched_reg;

endmodule

[design/prt_checker.sv]
// ----------------------------------------------------------------------------
// prt_checker
// Port-level checks of the ping round-trip tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prt_checker
    import prt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [TAG_W-1:0]  issued_tag,
    input logic [TIME_W-1:0] average_ms,
    input logic              tag_matched
);

    // An accepted item always occupies the block
    `ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted item did not raise busy")

    // Result strobe only when the block has finished its item
    `ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy, "result strobe while busy")

    // Busy ends only with a result
    `ASSERT_IMP(a_fall_done, clk, rst_n, $fell(busy), done, "busy dropped without a result")

    // A single result per item
    `ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done, "result strobe longer than one cycle")

    // A matched reply result carries no issued tag and no average
    `ASSERT_IMP(a_one_field, clk, rst_n, done && tag_matched, issued_tag == '0 && average_ms == '0, "reply result with other fields set")

endmodule

bind ping_round_trip_tracker prt_checker u_prt_checker (.*);
